// ----- sv/keyed_frame_word_parser_top_defines.svh -----
// ----------------------------------------------------------------------------
// Keyed frame word parser assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef KEYED_FRAME_WORD_PARSER_TOP_DEFINES_SVH
`define KEYED_FRAME_WORD_PARSER_TOP_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define KFWP_ASSERT_IMPLY(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition holds in the cycle after the trigger.
`define KFWP_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ----- sv/kfwp_pkg.sv -----
// ----------------------------------------------------------------------------
// Keyed frame word parser package
// Event codes, register indexes, reset values and shared structs.
// ----------------------------------------------------------------------------
package kfwp_pkg;

    localparam int MAX_FRAME_CHARS_DEF = 64;
    localparam int CFG_IDX_W           = 3;

    localparam logic [7:0] DEFAULT_KEY    = 8'd85;
    localparam logic [6:0] WORD_COUNT_MAX = 7'd127;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_OPEN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CLOSE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_FIRST   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_LAST    = 3'd5;

    localparam logic [7:0] RST_FRAME_START = 8'd60;
    localparam logic [7:0] RST_FRAME_END   = 8'd62;
    localparam logic [7:0] RST_KEY_OPEN    = 8'd91;
    localparam logic [7:0] RST_KEY_CLOSE   = 8'd93;
    localparam logic [7:0] RST_SEP_FIRST   = 8'd49;
    localparam logic [7:0] RST_SEP_LAST    = 8'd57;

    typedef enum logic [1:0] {
        EV_WORD_CHAR   = 2'd0,
        EV_WORD_END    = 2'd1,
        EV_FRAME_DONE  = 2'd2,
        EV_FRAME_ABORT = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic [7:0] frame_start;
        logic [7:0] frame_end;
        logic [7:0] key_open;
        logic [7:0] key_close;
        logic [7:0] sep_first;
        logic [7:0] sep_last;
    } cfg_t;

    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  word_char;
        logic [7:0]  frame_key;
        logic [6:0]  word_number;
    } result_t;

endpackage

// ----- sv/kfwp_cfg.sv -----
// ----------------------------------------------------------------------------
// Keyed frame word parser register file
// Holds the six character registers written through the configuration port.
// ----------------------------------------------------------------------------
module kfwp_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [kfwp_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [7:0]                     wr_data,
    output kfwp_pkg::cfg_t                 cfg
);
    import kfwp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_FRAME_START: cfg_next.frame_start = wr_data;
                CFG_FRAME_END:   cfg_next.frame_end   = wr_data;
                CFG_KEY_OPEN:    cfg_next.key_open    = wr_data;
                CFG_KEY_CLOSE:   cfg_next.key_close   = wr_data;
                CFG_SEP_FIRST:   cfg_next.sep_first   = wr_data;
                CFG_SEP_LAST:    cfg_next.sep_last    = wr_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_start <= RST_FRAME_START;
            cfg_reg.frame_end   <= RST_FRAME_END;
            cfg_reg.key_open    <= RST_KEY_OPEN;
            cfg_reg.key_close   <= RST_KEY_CLOSE;
            cfg_reg.sep_first   <= RST_SEP_FIRST;
            cfg_reg.sep_last    <= RST_SEP_LAST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/kfwp_core.sv -----
// ----------------------------------------------------------------------------
// Keyed frame word parser decode core
// Frame state registers and the per-byte decision logic.
// ----------------------------------------------------------------------------
module kfwp_core #(
    parameter int MAX_FRAME_CHARS = kfwp_pkg::MAX_FRAME_CHARS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  kfwp_pkg::cfg_t    cfg,
    output logic              res_valid,
    output kfwp_pkg::result_t res
);
    import kfwp_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_CHARS + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_FRAME_CHARS);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    logic             in_frame_reg, in_frame_next;
    logic             in_key_reg, in_key_next;
    logic [7:0]       exp_sep_reg, exp_sep_next;
    logic [CNT_W-1:0] char_cnt_reg, char_cnt_next;
    logic [7:0]       key_reg, key_next;
    logic [6:0]       word_cnt_reg, word_cnt_next;

    logic is_sep;
    logic do_clear;
    logic reopen;

    assign is_sep = (rx_byte >= cfg.sep_first) && (rx_byte <= cfg.sep_last);

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        in_key_next     = in_key_reg;
        exp_sep_next    = exp_sep_reg;
        char_cnt_next   = char_cnt_reg;
        key_next        = key_reg;
        word_cnt_next   = word_cnt_reg;
        do_clear        = 1'b0;
        reopen          = 1'b0;
        res_valid       = 1'b0;
        res.kind        = EV_WORD_CHAR;
        res.word_char   = 8'd0;
        res.frame_key   = key_reg;
        res.word_number = word_cnt_reg;

        priority if (in_frame_reg && (char_cnt_reg >= CNT_LIMIT))
        begin
            // Overlong frame: abort, and the byte may open a new frame at once.
            res_valid = 1'b1;
            res.kind  = EV_FRAME_ABORT;
            do_clear  = 1'b1;
            reopen    = (rx_byte == cfg.frame_start);
        end
        else if (!in_frame_reg)
        begin
            reopen   = (rx_byte == cfg.frame_start);
            do_clear = reopen;
        end
        else if (is_sep && (rx_byte != exp_sep_reg))
        begin
            res_valid = 1'b1;
            res.kind  = EV_FRAME_ABORT;
            do_clear  = 1'b1;
        end
        else
        begin
            if (is_sep)
            begin
                exp_sep_next = exp_sep_reg + 8'd1;
            end
            priority if (rx_byte == cfg.key_open)
            begin
                in_key_next = 1'b1;
            end
            else if (in_key_reg && (rx_byte != cfg.key_close))
            begin
                key_next = rx_byte;
            end
            else if (rx_byte == cfg.key_close)
            begin
                in_key_next = 1'b0;
            end
            else if (rx_byte == cfg.frame_end)
            begin
                res_valid = 1'b1;
                res.kind  = EV_FRAME_DONE;
                do_clear  = 1'b1;
            end
            else
            begin
                res_valid = 1'b1;
                if (is_sep)
                begin
                    res.kind = EV_WORD_END;
                    if (word_cnt_reg != WORD_COUNT_MAX)
                    begin
                        word_cnt_next = word_cnt_reg + 7'd1;
                    end
                end
                else
                begin
                    res.kind      = EV_WORD_CHAR;
                    res.word_char = rx_byte;
                end
                char_cnt_next = char_cnt_reg + CNT_ONE;
            end
        end

        if (do_clear)
        begin
            in_frame_next = reopen;
            in_key_next   = 1'b0;
            exp_sep_next  = cfg.sep_first;
            char_cnt_next = '0;
            key_next      = DEFAULT_KEY;
            word_cnt_next = 7'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            in_key_reg   <= 1'b0;
            exp_sep_reg  <= RST_SEP_FIRST;
            char_cnt_reg <= '0;
            key_reg      <= DEFAULT_KEY;
            word_cnt_reg <= 7'd0;
        end
        else if (accept)
        begin
            in_frame_reg <= in_frame_next;
            in_key_reg   <= in_key_next;
            exp_sep_reg  <= exp_sep_next;
            char_cnt_reg <= char_cnt_next;
            key_reg      <= key_next;
            word_cnt_reg <= word_cnt_next;
        end
    end

endmodule

// ----- sv/kfwp_out.sv -----
// ----------------------------------------------------------------------------
// Keyed frame word parser result register
// One-beat output register that loads while the previous beat drains.
// ----------------------------------------------------------------------------
module kfwp_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              res_valid,
    input  kfwp_pkg::result_t res,
    input  logic              out_stall,
    output logic              full,
    output kfwp_pkg::result_t res_out
);
    import kfwp_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        priority if (load && res_valid)
        begin
            valid_next = 1'b1;
            data_next  = res;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign full    = valid_reg;
    assign res_out = data_reg;

endmodule

// ----- sv/keyed_frame_word_parser_top.sv -----
// ----------------------------------------------------------------------------
// Keyed frame word parser
// Deframes keyed, separator-split messages arriving one byte per beat.
// ----------------------------------------------------------------------------
//  Channel  | Handshake              | Payload
//  ---------+------------------------+------------------------------------------
//  input    | in_valid / in_stall    | rx_byte
//  output   | out_valid / out_stall  | event_kind, word_char, frame_key, word_number
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One byte is taken per clock while in_stall is low; its result appears on the output in the following cycle.
// The frame state and the result register both update in the accepting cycle.
// in_stall rises only while a result sits in the output register and out_stall holds it.
// Reset is asynchronous; config registers return to their defaults, no clearing pass.
// ----------------------------------------------------------------------------
`include "keyed_frame_word_parser_top_defines.svh"

module keyed_frame_word_parser_top #(
    parameter int MAX_FRAME_CHARS = kfwp_pkg::MAX_FRAME_CHARS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     event_kind,
    output logic [7:0]                     word_char,
    output logic [7:0]                     frame_key,
    output logic [6:0]                     word_number,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kfwp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);
    import kfwp_pkg::*;

    cfg_t    cfg;
    result_t core_res;
    result_t out_res;
    logic    core_res_valid;
    logic    out_full;
    logic    accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_full && out_stall;
    assign accept    = in_valid && !in_stall;

    kfwp_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    kfwp_core #(
        .MAX_FRAME_CHARS (MAX_FRAME_CHARS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .cfg       (cfg),
        .res_valid (core_res_valid),
        .res       (core_res)
    );

    kfwp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res_valid (core_res_valid),
        .res       (core_res),
        .out_stall (out_stall),
        .full      (out_full),
        .res_out   (out_res)
    );

    assign out_valid   = out_full;
    assign event_kind  = out_res.kind;
    assign word_char   = out_res.word_char;
    assign frame_key   = out_res.frame_key;
    assign word_number = out_res.word_number;

    // Only word character beats carry a byte.
    `KFWP_ASSERT_IMPLY(a_char_only_on_word, out_valid && (event_kind != EV_WORD_CHAR), word_char == 8'd0, "word_char set on a non-character result")
    // The input side is held back only by a waiting result.
    `KFWP_ASSERT_IMPLY(a_stall_needs_result, in_stall, out_valid, "input stalled with empty output register")
    // A byte that produces a result is always presented on the next cycle.
    `KFWP_ASSERT_NEXT(a_result_lands, accept && core_res_valid, out_valid, "accepted result not presented")

endmodule
